>>> rtl/tlpr_pkg.sv
package tlpr_pkg;

    // Strip geometry.
    localparam int LINE_CHARS  = 26;
    localparam int LINE_WIDTH  = 320;
    localparam int LINE_HEIGHT = 16;

    // Cell and glyph geometry.
    localparam int CELL_PIXELS = 12;
    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_PIXEL_ROWS = 14;

    // Field widths of the words.
    localparam int FUNC_W  = 2;
    localparam int POS_W   = 5;
    localparam int CODE_W  = 8;
    localparam int LEN_W   = 5;
    localparam int X_W     = 9;
    localparam int Y_W     = 4;
    localparam int COLOR_W = 16;

    // Derived widths.
    localparam int CHAR_IDX_W = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
    localparam int CELL_W     = $clog2(LINE_WIDTH / CELL_PIXELS + 1);
    localparam int CMP_W      = (CELL_W > LEN_W) ? CELL_W : LEN_W;
    localparam int COL_W      = 3;
    localparam int ROW_W      = 3;

    // Reciprocal of the cell width, exact for every column below 1024.
    localparam int RECIP_SHIFT = 15;
    localparam int RECIP_W     = 12;
    localparam int RECIP       = (1 << RECIP_SHIFT) / CELL_PIXELS + 1;

    // Function codes of an input word.
    localparam logic [FUNC_W-1:0] FUNC_WRITE_CHAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET_LINE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PIXEL      = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGHLIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_BG  = 2'd2;

    // Register reset values.
    localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 16'hffff;
    localparam logic [COLOR_W-1:0] HIGHLIGHT_RESET  = 16'h001f;
    localparam logic [COLOR_W-1:0] NORMAL_BG_RESET  = 16'h0000;

    // Character codes with glyphs of their own.
    localparam logic [CODE_W-1:0] CH_COLON      = 8'h3a;
    localparam logic [CODE_W-1:0] CH_PERIOD     = 8'h2e;
    localparam logic [CODE_W-1:0] CH_MINUS      = 8'h2d;
    localparam logic [CODE_W-1:0] CH_SLASH      = 8'h2f;
    localparam logic [CODE_W-1:0] CH_UNDERSCORE = 8'h5f;
    localparam logic [CODE_W-1:0] CH_PERCENT    = 8'h25;
    localparam logic [CODE_W-1:0] CH_UPPER_A    = 8'h41;
    localparam logic [CODE_W-1:0] CH_DIGIT_0    = 8'h30;
    localparam logic [CODE_W-1:0] CASE_OFFSET   = 8'h20;

    // Input word, output word and the job passed from front to back.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  char_pos;
        logic [CODE_W-1:0] char_code;
        logic [LEN_W-1:0]  text_length;
        logic              selected;
        logic [X_W-1:0]    pixel_x;
        logic [Y_W-1:0]    pixel_y;
    } t_in_word;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_color;
        logic               pixel_lit;
    } t_out_word;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              active;
        logic              highlight;
    } t_job;

    typedef logic [GLYPH_COLS*GLYPH_ROWS-1:0] t_glyph;

    // Pack five glyph columns, column 0 in the low bits.
    function automatic t_glyph pack5(input logic [6:0] c0, input logic [6:0] c1,
                                     input logic [6:0] c2, input logic [6:0] c3,
                                     input logic [6:0] c4);
        return {c4, c3, c2, c1, c0};
    endfunction

    localparam t_glyph FONT_ALPHA [26] = '{
        pack5(126,   9,   9,   9, 126), pack5(127,  73,  73,  73,  54),
        pack5( 62,  65,  65,  65,  34), pack5(127,  65,  65,  34,  28),
        pack5(127,  73,  73,  73,  65), pack5(127,   9,   9,   9,   1),
        pack5( 62,  65,  73,  73, 122), pack5(127,   8,   8,   8, 127),
        pack5( 65,  65, 127,  65,  65), pack5( 32,  64,  65,  63,   1),
        pack5(127,   8,  20,  34,  65), pack5(127,  64,  64,  64,  64),
        pack5(127,   2,  12,   2, 127), pack5(127,   4,   8,  16, 127),
        pack5( 62,  65,  65,  65,  62), pack5(127,   9,   9,   9,   6),
        pack5( 62,  65,  81,  33,  94), pack5(127,   9,  25,  41,  70),
        pack5( 38,  73,  73,  73,  50), pack5(  1,   1, 127,   1,   1),
        pack5( 63,  64,  64,  64,  63), pack5( 31,  32,  64,  32,  31),
        pack5( 63,  64,  56,  64,  63), pack5( 99,  20,   8,  20,  99),
        pack5(  3,   4, 120,   4,   3), pack5( 97,  81,  73,  69,  67)
    };

    localparam t_glyph FONT_NUM [10] = '{
        pack5( 62,  81,  73,  69,  62), pack5(  0,  66, 127,  64,   0),
        pack5( 98,  81,  73,  73,  70), pack5( 34,  65,  73,  73,  54),
        pack5( 24,  20,  18, 127,  16), pack5( 39,  69,  69,  69,  57),
        pack5( 62,  73,  73,  73,  50), pack5(  1, 113,   9,   5,   3),
        pack5( 54,  73,  73,  73,  54), pack5( 38,  73,  73,  73,  62)
    };

    localparam t_glyph GLYPH_COLON      = pack5(0, 0, 36, 0, 0);
    localparam t_glyph GLYPH_PERIOD     = pack5(0, 0, 64, 0, 0);
    localparam t_glyph GLYPH_MINUS      = pack5(8, 8, 8, 8, 8);
    localparam t_glyph GLYPH_SLASH      = pack5(64, 32, 16, 8, 4);
    localparam t_glyph GLYPH_UNDERSCORE = pack5(64, 64, 64, 64, 64);
    localparam t_glyph GLYPH_PERCENT    = pack5(99, 32, 16, 8, 99);

    // Dot column of a character; bit r is glyph row r from the top.
    function automatic logic [GLYPH_ROWS-1:0] font_column(input logic [CODE_W-1:0] code,
                                                          input logic [COL_W-1:0] col);
        logic [CODE_W-1:0] ch;
        t_glyph            g;
        ch = code;
        g  = '0;
        if (ch inside {[8'h61:8'h7a]}) begin
            ch = ch - CASE_OFFSET;
        end
        if (ch inside {[8'h41:8'h5a]}) begin
            g = FONT_ALPHA[5'(ch - CH_UPPER_A)];
        end else if (ch inside {[8'h30:8'h39]}) begin
            g = FONT_NUM[4'(ch - CH_DIGIT_0)];
        end else begin
            case (ch)
                CH_COLON:      g = GLYPH_COLON;
                CH_PERIOD:     g = GLYPH_PERIOD;
                CH_MINUS:      g = GLYPH_MINUS;
                CH_SLASH:      g = GLYPH_SLASH;
                CH_UNDERSCORE: g = GLYPH_UNDERSCORE;
                CH_PERCENT:    g = GLYPH_PERCENT;
                default:       g = '0;
            endcase
        end
        if (int'(col) < GLYPH_COLS) begin
            return g[int'(col)*GLYPH_ROWS +: GLYPH_ROWS];
        end
        return '0;
    endfunction

endpackage

>>> rtl/tlpr_front.sv
module tlpr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  tlpr_pkg::t_in_word i_in_word,
    input  logic              i_q_full,
    output logic              o_push,
    output tlpr_pkg::t_job    o_job
);

    // Text cells carry no reset: a cell is defined once written.
    logic [tlpr_pkg::CODE_W-1:0] r_cells [tlpr_pkg::LINE_CHARS];
    logic [tlpr_pkg::LEN_W-1:0]  r_len;
    logic                        r_highlight;

    logic                                              accept;
    logic [tlpr_pkg::X_W+tlpr_pkg::RECIP_W-1:0]        prod;
    logic [tlpr_pkg::CELL_W-1:0]                       cell_num;
    logic [tlpr_pkg::X_W-1:0]                          rem;
    logic [tlpr_pkg::COL_W-1:0]                        col;
    logic                                              in_strip;
    logic                                              active;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // Split the column into cell and glyph column by a reciprocal multiply.
    assign prod = (tlpr_pkg::X_W+tlpr_pkg::RECIP_W)'(i_in_word.pixel_x)
                * (tlpr_pkg::X_W+tlpr_pkg::RECIP_W)'(tlpr_pkg::RECIP);
    assign cell_num = prod[tlpr_pkg::RECIP_SHIFT +: tlpr_pkg::CELL_W];
    assign rem  = i_in_word.pixel_x
                - tlpr_pkg::X_W'(cell_num) * tlpr_pkg::X_W'(tlpr_pkg::CELL_PIXELS);
    assign col  = rem[tlpr_pkg::COL_W:1];

    // The pixel lies on a glyph dot position of a cell inside the line.
    assign in_strip = ({1'b0, i_in_word.pixel_x} < (tlpr_pkg::X_W+1)'(tlpr_pkg::LINE_WIDTH))
                   && ({1'b0, i_in_word.pixel_y} < (tlpr_pkg::Y_W+1)'(tlpr_pkg::LINE_HEIGHT));
    assign active = in_strip
                 && (tlpr_pkg::CMP_W'(cell_num) < tlpr_pkg::CMP_W'(r_len))
                 && (int'(col) < tlpr_pkg::GLYPH_COLS)
                 && ({1'b0, i_in_word.pixel_y} < (tlpr_pkg::Y_W+1)'(tlpr_pkg::GLYPH_PIXEL_ROWS));

    // Build the job for the back end.
    always_comb begin
        o_push          = accept && (i_in_word.func == tlpr_pkg::FUNC_PIXEL);
        o_job.active    = active;
        o_job.col       = col;
        o_job.row       = i_in_word.pixel_y[tlpr_pkg::ROW_W:1];
        o_job.highlight = r_highlight;
        o_job.code      = active ? r_cells[tlpr_pkg::CHAR_IDX_W'(cell_num)] : '0;
    end

    // Line length and highlight flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_highlight <= 1'b0;
        end else if (accept && (i_in_word.func == tlpr_pkg::FUNC_SET_LINE)) begin
            if (int'(i_in_word.text_length) > tlpr_pkg::LINE_CHARS) begin
                r_len <= tlpr_pkg::LEN_W'(tlpr_pkg::LINE_CHARS);
            end else begin
                r_len <= i_in_word.text_length;
            end
            r_highlight <= i_in_word.selected;
        end
    end

    // Character writes; a position beyond the line is dropped.
    always_ff @(posedge i_clk) begin
        if (accept && (i_in_word.func == tlpr_pkg::FUNC_WRITE_CHAR)
                && (int'(i_in_word.char_pos) < tlpr_pkg::LINE_CHARS)) begin
            r_cells[tlpr_pkg::CHAR_IDX_W'(i_in_word.char_pos)] <= i_in_word.char_code;
        end
    end

endmodule

>>> rtl/tlpr_queue.sv
module tlpr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tlpr_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output tlpr_pkg::t_job o_job
);

    localparam int DEPTH = 2;

    tlpr_pkg::t_job r_mem [DEPTH];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic [1:0]     n_count;

    assign o_full  = (r_count == 2'(DEPTH));
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    // Job storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from an empty queue");

endmodule

>>> rtl/tlpr_back.sv
module tlpr_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  tlpr_pkg::t_job                i_job,
    output logic                          o_pop,
    input  logic [tlpr_pkg::COLOR_W-1:0]  i_foreground,
    input  logic [tlpr_pkg::COLOR_W-1:0]  i_highlight,
    input  logic [tlpr_pkg::COLOR_W-1:0]  i_normal_bg,
    output logic                          o_valid,
    input  logic                          i_ready,
    output tlpr_pkg::t_out_word           o_out_word
);

    logic                          r_out_valid;
    tlpr_pkg::t_out_word           r_out_word;
    logic [tlpr_pkg::GLYPH_ROWS-1:0] bits;
    logic                          lit;
    logic [tlpr_pkg::COLOR_W-1:0]  color;

    assign o_pop      = i_q_valid && (!r_out_valid || i_ready);
    assign o_valid    = r_out_valid;
    assign o_out_word = r_out_word;

    // Glyph lookup and color choice.
    always_comb begin
        bits  = tlpr_pkg::font_column(i_job.code, i_job.col);
        lit   = i_job.active && bits[i_job.row];
        color = lit ? i_foreground : (i_job.highlight ? i_highlight : i_normal_bg);
    end

    // Output register; the color leaves with its bytes swapped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_word.pixel_color <= {color[7:0], color[15:8]};
            r_out_word.pixel_lit   <= lit;
        end
    end

    a_pop_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out_valid)
        else $error("popped job did not reach the output register");

endmodule

>>> rtl/text_line_pixel_renderer_core.sv
// Text strip character generator for a 320 by 16 pixel line of 26 cells, 5x7 font drawn
// with 2x2 dots. One input word is taken per clock when the two-entry job queue has room:
// character writes and length/highlight updates take effect at the edge they are taken,
// and a pixel request passes through the job queue and then the output register. The front
// end resolves cell, glyph column and stored character; the back end does the font lookup
// and color choice from the queue head, so the sustained rate is one pixel per clock while
// the output side is ready. Configuration registers (foreground, highlight background,
// normal background) are written through i_cfg_we/i_cfg_idx/i_cfg_data with no wait;
// write them only while no pixel request is in flight. A text cell must be written before
// a visible pixel of it is requested.
module text_line_pixel_renderer_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  tlpr_pkg::t_in_word             i_in_word,
    output logic                           o_valid,
    input  logic                           i_ready,
    output tlpr_pkg::t_out_word            o_out_word,
    input  logic                           i_cfg_we,
    input  logic [tlpr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tlpr_pkg::COLOR_W-1:0]   i_cfg_data
);

    logic [tlpr_pkg::COLOR_W-1:0] r_foreground;
    logic [tlpr_pkg::COLOR_W-1:0] r_highlight;
    logic [tlpr_pkg::COLOR_W-1:0] r_normal_bg;

    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_valid;
    tlpr_pkg::t_job front_job;
    tlpr_pkg::t_job back_job;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_foreground <= tlpr_pkg::FOREGROUND_RESET;
            r_highlight  <= tlpr_pkg::HIGHLIGHT_RESET;
            r_normal_bg  <= tlpr_pkg::NORMAL_BG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tlpr_pkg::REG_FOREGROUND: r_foreground <= i_cfg_data;
                tlpr_pkg::REG_HIGHLIGHT:  r_highlight  <= i_cfg_data;
                tlpr_pkg::REG_NORMAL_BG:  r_normal_bg  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tlpr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_in_word (i_in_word),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_job     (front_job)
    );

    tlpr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (back_job)
    );

    tlpr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_job        (back_job),
        .o_pop        (pop),
        .i_foreground (r_foreground),
        .i_highlight  (r_highlight),
        .i_normal_bg  (r_normal_bg),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_word   (o_out_word)
    );

endmodule

>>> tb/text_line_pixel_renderer_core_tb.sv
`timescale 1ns / 1ps

module text_line_pixel_renderer_core_tb;

    // Strip geometry as the scan sees it.
    localparam int STRIP_CELLS    = 26;
    localparam int STRIP_WIDTH    = 320;
    localparam int CELL_WIDTH     = 12;
    localparam int DOT_COLS       = 5;
    localparam int DOT_PIXEL_ROWS = 14;

    // Run shape.
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_WORDS  = 450;
    localparam int PHASES        = 4;
    localparam int REPORT_LIMIT  = 10;
    localparam int IN_WORD_W     = $bits(tlpr_pkg::t_in_word);

    // Short names for the function codes used in the script.
    localparam logic [tlpr_pkg::FUNC_W-1:0] OP_CHAR  = tlpr_pkg::FUNC_WRITE_CHAR;
    localparam logic [tlpr_pkg::FUNC_W-1:0] OP_LINE  = tlpr_pkg::FUNC_SET_LINE;
    localparam logic [tlpr_pkg::FUNC_W-1:0] OP_PIXEL = tlpr_pkg::FUNC_PIXEL;

    // Codes with no meaning in the block.
    localparam logic [tlpr_pkg::FUNC_W-1:0]    FUNC_UNUSED  = 2'd3;
    localparam logic [tlpr_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct {
        tlpr_pkg::t_in_word  word;
        bit                  typed;
        tlpr_pkg::t_out_word res;
    } t_script_row;

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_valid    = 1'b0;
    logic                           o_ready;
    tlpr_pkg::t_in_word             i_in_word  = '0;
    logic                           o_valid;
    logic                           i_ready    = 1'b0;
    tlpr_pkg::t_out_word            o_out_word;
    logic                           i_cfg_we   = 1'b0;
    logic [tlpr_pkg::CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [tlpr_pkg::COLOR_W-1:0]   i_cfg_data = '0;

    // Shadow copy of the strip text, line settings and colors.
    logic [7:0]  strip_text [STRIP_CELLS];
    bit          cell_written [STRIP_CELLS];
    logic [4:0]  strip_len      = '0;
    logic        strip_selected = 1'b0;
    logic [15:0] fg_color       = 16'hffff;
    logic [15:0] hl_color       = 16'h001f;
    logic [15:0] bg_color       = 16'h0000;

    // Pixel words still owed by the block, oldest first.
    tlpr_pkg::t_out_word pixel_due [$];
    tlpr_pkg::t_out_word pixel_next;
    t_script_row         script [$];
    int                  mismatches = 0;
    int                  recv_hold  = 0;
    bit                  send_burst = 1'b0;
    bit                  recv_burst = 1'b0;
    string               glyph_set  = "AZaz09:.-/_%MqXw5 @[`{,;$&";

    text_line_pixel_renderer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in_word  (i_in_word),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_word (o_out_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Five dot columns of a character, column 0 in the top byte; bit r is row r.
    function automatic logic [39:0] glyph_dots(input logic [7:0] code);
        logic [7:0] ch;
        ch = code;
        if (ch >= "a" && ch <= "z") begin
            ch = ch - 8'h20;
        end
        case (ch)
            "A": return 40'h7e0909097e;
            "B": return 40'h7f49494936;
            "C": return 40'h3e41414122;
            "D": return 40'h7f4141221c;
            "E": return 40'h7f49494941;
            "F": return 40'h7f09090901;
            "G": return 40'h3e4149497a;
            "H": return 40'h7f0808087f;
            "I": return 40'h41417f4141;
            "J": return 40'h2040413f01;
            "K": return 40'h7f08142241;
            "L": return 40'h7f40404040;
            "M": return 40'h7f020c027f;
            "N": return 40'h7f0408107f;
            "O": return 40'h3e4141413e;
            "P": return 40'h7f09090906;
            "Q": return 40'h3e4151215e;
            "R": return 40'h7f09192946;
            "S": return 40'h2649494932;
            "T": return 40'h01017f0101;
            "U": return 40'h3f4040403f;
            "V": return 40'h1f2040201f;
            "W": return 40'h3f4038403f;
            "X": return 40'h6314081463;
            "Y": return 40'h0304780403;
            "Z": return 40'h6151494543;
            "0": return 40'h3e5149453e;
            "1": return 40'h00427f4000;
            "2": return 40'h6251494946;
            "3": return 40'h2241494936;
            "4": return 40'h1814127f10;
            "5": return 40'h2745454539;
            "6": return 40'h3e49494932;
            "7": return 40'h0171090503;
            "8": return 40'h3649494936;
            "9": return 40'h264949493e;
            ":": return 40'h0000240000;
            ".": return 40'h0000400000;
            "-": return 40'h0808080808;
            "/": return 40'h4020100804;
            "_": return 40'h4040404040;
            "%": return 40'h6320100863;
            default: return '0;
        endcase
    endfunction

    // Color and dot flag the strip shows at one pixel.
    function automatic tlpr_pkg::t_out_word predict_pixel(input logic [8:0] x,
                                                          input logic [3:0] y);
        int                  cell_idx;
        int                  col;
        logic [39:0]         dots;
        logic [7:0]          column;
        logic [15:0]         color;
        tlpr_pkg::t_out_word res;
        cell_idx      = int'(x) / CELL_WIDTH;
        col           = (int'(x) % CELL_WIDTH) / 2;
        res.pixel_lit = 1'b0;
        if (x < STRIP_WIDTH && cell_idx < strip_len && col < DOT_COLS && y < DOT_PIXEL_ROWS) begin
            dots          = glyph_dots(strip_text[cell_idx]);
            column        = dots[39 - 8 * col -: 8];
            res.pixel_lit = column[y / 2];
        end
        color = res.pixel_lit ? fg_color : (strip_selected ? hl_color : bg_color);
        res.pixel_color = {color[7:0], color[15:8]};
        return res;
    endfunction

    function automatic t_script_row row_of(input logic [tlpr_pkg::FUNC_W-1:0] func,
                                           input int pos,
                                           input int code, input int len, input bit sel,
                                           input int x, input int y, input bit typed,
                                           input logic [15:0] color, input bit lit);
        t_script_row r;
        r.word.func            = func;
        r.word.char_pos        = 5'(pos);
        r.word.char_code       = 8'(code);
        r.word.text_length     = 5'(len);
        r.word.selected        = sel;
        r.word.pixel_x         = 9'(x);
        r.word.pixel_y         = 4'(y);
        r.typed                = typed;
        r.res.pixel_color      = color;
        r.res.pixel_lit        = lit;
        return r;
    endfunction

    // Offer one word after a random pause, then fold it into the shadow state.
    task automatic send_word(input tlpr_pkg::t_in_word w, input bit typed,
                             input tlpr_pkg::t_out_word typed_res);
        int gap;
        if ($urandom_range(0, 31) == 0) begin
            send_burst = !send_burst;
        end
        gap = send_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_word <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        case (w.func)
            tlpr_pkg::FUNC_WRITE_CHAR: begin
                if (w.char_pos < STRIP_CELLS) begin
                    strip_text[w.char_pos]   = w.char_code;
                    cell_written[w.char_pos] = 1'b1;
                end
            end
            tlpr_pkg::FUNC_SET_LINE: begin
                strip_len      = (w.text_length > STRIP_CELLS) ? 5'(STRIP_CELLS) : w.text_length;
                strip_selected = w.selected;
            end
            tlpr_pkg::FUNC_PIXEL: begin
                pixel_due.push_back(typed ? typed_res : predict_pixel(w.pixel_x, w.pixel_y));
            end
            default: begin
            end
        endcase
    endtask

    // Let the block drain, then load a new color set and poke the unmapped index.
    task automatic settle_and_configure(input logic [15:0] fg, input logic [15:0] hl,
                                        input logic [15:0] bg);
        i_valid <= 1'b0;
        while (pixel_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= tlpr_pkg::REG_FOREGROUND;
        i_cfg_data <= fg;
        @(posedge i_clk);
        fg_color   = fg;
        i_cfg_idx  <= tlpr_pkg::REG_HIGHLIGHT;
        i_cfg_data <= hl;
        @(posedge i_clk);
        hl_color   = hl;
        i_cfg_idx  <= tlpr_pkg::REG_NORMAL_BG;
        i_cfg_data <= bg;
        @(posedge i_clk);
        bg_color   = bg;
        i_cfg_idx  <= REG_UNMAPPED;
        i_cfg_data <= 16'($urandom);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Check each pixel word against the oldest one owed and pick the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pixel_due.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("unexpected pixel word: color %h lit %b",
                                 o_out_word.pixel_color, o_out_word.pixel_lit);
                    end
                end else begin
                    pixel_next = pixel_due.pop_front();
                    if (o_out_word.pixel_color !== pixel_next.pixel_color ||
                        o_out_word.pixel_lit !== pixel_next.pixel_lit) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("pixel mismatch: expected color %h lit %b, got color %h lit %b",
                                     pixel_next.pixel_color, pixel_next.pixel_lit,
                                     o_out_word.pixel_color, o_out_word.pixel_lit);
                        end
                    end
                end
                if ($urandom_range(0, 31) == 0) begin
                    recv_burst = !recv_burst;
                end
                recv_hold = recv_burst ? 0 : $urandom_range(0, 15);
            end else if (recv_hold > 0) begin
                recv_hold = recv_hold - 1;
            end
            i_ready <= (recv_hold == 0);
        end
    end

    initial begin
        tlpr_pkg::t_in_word  w;
        tlpr_pkg::t_out_word none;
        int                  pick;
        none = '0;

        // Directed rows: reset state, every glyph class, and the blank cases.
        script.push_back(row_of(OP_PIXEL,     0,     0,  0, 0,   0,  0, 1, 16'h0000, 0));
        script.push_back(row_of(OP_LINE,      0,     0,  0, 1,   0,  0, 0, 16'h0000, 0));
        script.push_back(row_of(OP_PIXEL,     0,     0,  0, 0, 319, 15, 1, 16'h1f00, 0));
        script.push_back(row_of(OP_CHAR,      0,   "A",  0, 0,   0,  0, 0, 16'h0000, 0));
        script.push_back(row_of(OP_CHAR,      1,   "z",  0, 0,   0,  0, 0, 16'h0000, 0));
        script.push_back(row_of(OP_CHAR,      2,   "0",  0, 0,   0,  0, 0, 16'h0000, 0));
        script.push_back(row_of(OP_CHAR,      3,   "9",  0, 0,   0,  0, 0, 16'h0000, 0));
        script.push_back(row_of(OP_CHAR,      4,   ":",  0, 0,   0,  0, 0, 16'h0000, 0));
        script.push_back(row_of(OP_CHAR,      5,   ".",  0, 0,   0,  0, 0, 16'h0000, 0));
        script.push_back(row_of(OP_CHAR,      6,   "-",  0, 0,   0,  0, 0, 16'h0000, 0));
        script.push_back(row_of(OP_CHAR,      7,   "/",  0, 0,   0,  0, 0, 16'h0000, 0));
        script.push_back(row_of(OP_CHAR,      8,   "_",  0, 0,   0,  0, 0, 16'h0000, 0));
        script.push_back(row_of(OP_CHAR,      9,   "%",  0, 0,   0,  0, 0, 16'h0000, 0));
        script.push_back(row_of(OP_CHAR,     10, 8'hff,  0, 0,   0,  0, 0, 16'h0000, 0));
        script.push_back(row_of(OP_CHAR,     11, 8'h00,  0, 0,   0,  0, 0, 16'h0000, 0));
        script.push_back(row_of(OP_CHAR,     25, 8'h80,  0, 0,   0,  0, 0, 16'h0000, 0));
        // A write past the last cell must leave the strip alone.
        script.push_back(row_of(OP_CHAR,     31,   "A",  0, 0,   0,  0, 0, 16'h0000, 0));
        // A length above the cell count saturates to the full strip.
        script.push_back(row_of(OP_LINE,      0,     0, 31, 0,   0,  0, 0, 16'h0000, 0));
        script.push_back(row_of(OP_PIXEL,     0,     0,  0, 0,   0,  2, 1, 16'hffff, 1));
        script.push_back(row_of(OP_PIXEL,     0,     0,  0, 0,  10,  4, 1, 16'h0000, 0));
        script.push_back(row_of(OP_PIXEL,     0,     0,  0, 0,   4, 14, 1, 16'h0000, 0));
        script.push_back(row_of(OP_PIXEL,     0,     0,  0, 0, 511,  7, 1, 16'h0000, 0));
        script.push_back(row_of(OP_PIXEL,     0,     0,  0, 0,  16, 13, 0, 16'h0000, 0));
        script.push_back(row_of(OP_PIXEL,     0,     0,  0, 0, 308,  0, 0, 16'h0000, 0));
        script.push_back(row_of(FUNC_UNUSED, 31,   255, 31, 1, 511, 15, 0, 16'h0000, 0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            send_word(script[i].word, script[i].typed, script[i].res);
        end

        // Random words over several color sets; pixels never touch an unwritten cell.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                1: settle_and_configure(16'h0000, 16'hffff, 16'hffff);
                2: settle_and_configure(16'hffff, 16'h0000, 16'h0000);
                3: settle_and_configure(16'($urandom), 16'($urandom), 16'($urandom));
                default: begin
                end
            endcase
            for (int n = 0; n < RANDOM_WORDS / PHASES; n++) begin
                w    = tlpr_pkg::t_in_word'(IN_WORD_W'({$urandom, $urandom}));
                pick = $urandom_range(0, 99);
                if (pick < 62) begin
                    w.func = OP_PIXEL;
                    do begin
                        w.pixel_x = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                                                 : 9'($urandom_range(0, 319));
                    end while (w.pixel_x < STRIP_WIDTH && w.pixel_x / CELL_WIDTH < strip_len &&
                               !cell_written[w.pixel_x / CELL_WIDTH]);
                end else if (pick < 82) begin
                    w.func      = OP_CHAR;
                    w.char_pos  = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(26, 31))
                                                               : 5'($urandom_range(0, 25));
                    w.char_code = ($urandom_range(0, 1) == 1)
                                  ? 8'(glyph_set[$urandom_range(0, glyph_set.len() - 1)])
                                  : 8'($urandom_range(0, 255));
                end else if (pick < 94) begin
                    w.func = OP_LINE;
                end else begin
                    w.func = FUNC_UNUSED;
                end
                send_word(w, 1'b0, none);
            end
        end

        i_valid <= 1'b0;
        while (pixel_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
